>>> hw/rtl/eso_pkg.sv
`timescale 1ns / 1ps

package eso_pkg;

    localparam int ESO_TIME_BITS = 24;
    localparam int ESO_FRAC_BITS = 16;
    localparam int CFG_DATA_W    = 24;
    localparam int DIST_W        = 16;
    localparam int PHASE_W       = 3;
    localparam int CFG_IDX_W     = 2;

    // register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELAY = 2'd0,
        CFG_MOVE  = 2'd1,
        CFG_DIST  = 2'd2,
        CFG_MODE  = 2'd3
    } t_cfg_idx;

    // phase codes as reported on the result port
    typedef enum logic [PHASE_W-1:0] {
        PH_WAIT = 3'd0,
        PH_OUT  = 3'd1,
        PH_HOLD = 3'd2,
        PH_BACK = 3'd3,
        PH_DONE = 3'd4
    } t_phase;

    // control that travels alongside each beat
    typedef struct packed {
        logic   vld;
        t_phase phase;
    } t_side;

endpackage

>>> hw/rtl/eso_div_cell.sv
`timescale 1ns / 1ps

// One restoring-division step: one quotient bit per cell.
module eso_div_cell #(
    parameter int TW = eso_pkg::ESO_TIME_BITS,
    parameter int FB = eso_pkg::ESO_FRAC_BITS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [TW-1:0]  i_div,
    input  eso_pkg::t_side i_side,
    input  logic [TW-1:0]  i_rem,
    input  logic [FB-1:0]  i_quo,
    output eso_pkg::t_side o_side,
    output logic [TW-1:0]  o_rem,
    output logic [FB-1:0]  o_quo
);

    eso_pkg::t_side r_side;
    logic [TW-1:0]  r_rem;
    logic [FB-1:0]  r_quo;
    logic [TW:0]    w_shift;
    logic [TW:0]    w_diff;
    logic           w_ge;

    // shift in a zero and try the subtract
    always_comb begin
        w_shift = {i_rem, 1'b0};
        w_ge    = w_shift >= {1'b0, i_div};
        w_diff  = w_shift - {1'b0, i_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side.vld <= 1'b0;
        end else begin
            r_side.vld <= i_side.vld;
        end
        r_side.phase <= i_side.phase;
        r_rem <= w_ge ? w_diff[TW-1:0] : w_shift[TW-1:0];
        r_quo <= {i_quo[FB-2:0], w_ge};
    end

    assign o_side = r_side;
    assign o_rem  = r_rem;
    assign o_quo  = r_quo;

endmodule

>>> hw/rtl/eso_ease.sv
`timescale 1ns / 1ps

// Smootherstep easing (linear in mode 1) and distance scaling.
module eso_ease #(
    parameter int FB = eso_pkg::ESO_FRAC_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_mode,
    input  logic [eso_pkg::DIST_W-1:0]  i_dist,
    input  eso_pkg::t_side              i_side,
    input  logic [FB-1:0]               i_frac,
    output eso_pkg::t_side              o_side,
    output logic [eso_pkg::DIST_W-1:0]  o_offset
);

    localparam int PW = FB + 4;
    localparam int DW = eso_pkg::DIST_W;
    localparam logic [FB:0] ONE = {1'b1, {FB{1'b0}}};

    eso_pkg::t_side r_side1, r_side2, r_side3, r_side4, r_side5;
    logic [FB-1:0]  r_f1, r_f2, r_f3;
    logic [FB-1:0]  r_x2;
    logic [FB-1:0]  r_x3;
    logic [PW-1:0]  r_p;
    logic [FB:0]    r_s;
    logic [DW-1:0]  r_sc;
    logic [DW-1:0]  r_off;

    logic [2*FB-1:0] w_x2_full;
    logic [2*FB-1:0] w_x3_full;
    logic [PW:0]     w_pos;
    logic [PW:0]     w_neg;
    logic [2*FB+3:0] w_s_full;
    logic [PW-1:0]   w_s_sh;
    logic [FB:0]     w_sel;
    logic [DW+FB:0]  w_sc_full;

    function automatic logic [DW+FB:0] sel_mul(input logic [DW-1:0] a,
                                               input logic [FB:0] b);
        sel_mul = a * b;
    endfunction

    always_comb begin
        w_x2_full = i_frac * i_frac;
        w_x3_full = r_x2 * r_f1;
        w_pos     = (PW+1)'(r_x2) * (PW+1)'(6) + (PW+1)'({ONE, 3'b000})
                    + (PW+1)'({ONE, 1'b0});
        w_neg     = (PW+1)'(r_f1) * (PW+1)'(15);
        w_s_full  = r_x3 * r_p;
        w_s_sh    = w_s_full[2*FB+3:FB];
        w_sel     = i_mode ? {1'b0, r_f3} : r_s;
        w_sc_full = sel_mul(i_dist, w_sel);
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side1.vld <= 1'b0;
            r_side2.vld <= 1'b0;
            r_side3.vld <= 1'b0;
            r_side4.vld <= 1'b0;
            r_side5.vld <= 1'b0;
        end else begin
            r_side1.vld <= i_side.vld;
            r_side2.vld <= r_side1.vld;
            r_side3.vld <= r_side2.vld;
            r_side4.vld <= r_side3.vld;
            r_side5.vld <= r_side4.vld;
        end
        r_side1.phase <= i_side.phase;
        r_side2.phase <= r_side1.phase;
        r_side3.phase <= r_side2.phase;
        r_side4.phase <= r_side3.phase;
        r_side5.phase <= r_side4.phase;
    end

    // datapath
    always_ff @(posedge i_clk) begin
        // x^2
        r_x2 <= w_x2_full[2*FB-1:FB];
        r_f1 <= i_frac;
        // x^3 and the polynomial 6x^2 - 15x + 10
        r_x3 <= w_x3_full[2*FB-1:FB];
        r_p  <= (w_pos > w_neg) ? PW'(w_pos - w_neg) : '0;
        r_f2 <= r_f1;
        // s = x^3 * p, capped at one
        r_s  <= (w_s_sh > PW'(ONE)) ? ONE : w_s_sh[FB:0];
        r_f3 <= r_f2;
        // scale by distance
        r_sc <= w_sc_full[DW+FB-1:FB];
        // select by phase
        case (r_side4.phase)
            eso_pkg::PH_OUT:  r_off <= r_sc;
            eso_pkg::PH_HOLD: r_off <= i_dist;
            eso_pkg::PH_BACK: r_off <= i_dist - r_sc;
            default:          r_off <= '0;
        endcase
    end

    assign o_side   = r_side5;
    assign o_offset = r_off;

endmodule

>>> hw/rtl/eased_scroll_offset_core.sv
`timescale 1ns / 1ps

// Eased marquee scroll offset.
// Configuration: write channel i_cfg_valid / o_cfg_ready with i_cfg_index and
// i_cfg_data; o_cfg_ready is always high. Index 0 delay ticks, 1 move ticks,
// 2 scroll distance (Q12.4), 3 mode (0 bounce with smootherstep, 1 loop).
// Write only while no beat is in flight.
// Query: a beat of i_now_ticks is taken at each edge where i_start is high
// and o_busy is low; o_busy is always low, so one query per cycle.
// Result: o_offset and o_phase appear for one cycle with o_valid. Results come out
// in query order and cannot be held off by the receiver.
// A query passes a registered phase decode, then the row of division cells,
// one quotient bit each, then four easing stages and the output register.
// Throughput is one query per cycle.
// Reset (synchronous, active low) clears the configuration registers to 0
// and empties the pipeline; no result is produced for beats in flight at reset.
module eased_scroll_offset_core #(
    parameter int TIME_BITS = eso_pkg::ESO_TIME_BITS,
    parameter int FRAC_BITS = eso_pkg::ESO_FRAC_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [eso_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [eso_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic [TIME_BITS-1:0]           i_now_ticks,
    output logic                           o_valid,
    output logic [eso_pkg::DIST_W-1:0]     o_offset,
    output logic [eso_pkg::PHASE_W-1:0]    o_phase
);

    localparam int TW = (TIME_BITS < eso_pkg::CFG_DATA_W) ? TIME_BITS
                                                          : eso_pkg::CFG_DATA_W;
    localparam int FB = FRAC_BITS;
    localparam int SW = TW + 2;

    logic [eso_pkg::CFG_DATA_W-1:0] r_delay;
    logic [eso_pkg::CFG_DATA_W-1:0] r_move;
    logic [eso_pkg::DIST_W-1:0]     r_dist;
    logic                           r_mode;

    eso_pkg::t_side r_side0;
    logic [TW-1:0]  r_elap;

    logic [TW-1:0]  w_t, w_d, w_m;
    logic [SW-1:0]  w_end_wait, w_end_out, w_end_hold, w_end_back, w_t_ext;
    logic [SW-1:0]  w_elap;
    eso_pkg::t_phase w_phase;

    eso_pkg::t_side w_side [0:FB];
    logic [TW-1:0]  w_rem  [0:FB];
    logic [FB-1:0]  w_quo  [0:FB];

    eso_pkg::t_side w_out_side;
    logic           w_acc;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = 1'b0;
    assign w_acc       = i_start;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= '0;
            r_move  <= '0;
            r_dist  <= '0;
            r_mode  <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                eso_pkg::CFG_DELAY: r_delay <= i_cfg_data;
                eso_pkg::CFG_MOVE:  r_move  <= i_cfg_data;
                eso_pkg::CFG_DIST:  r_dist  <= i_cfg_data[eso_pkg::DIST_W-1:0];
                eso_pkg::CFG_MODE:  r_mode  <= i_cfg_data[0];
                default:            r_mode  <= r_mode;
            endcase
        end
    end

    // phase decode and elapsed time within the moving phase
    always_comb begin
        w_t        = i_now_ticks[TW-1:0];
        w_d        = r_delay[TW-1:0];
        w_m        = r_move[TW-1:0];
        w_t_ext    = SW'(w_t);
        w_end_wait = SW'(w_d);
        w_end_out  = w_end_wait + SW'(w_m);
        w_end_hold = w_end_out + SW'(w_d);
        w_end_back = w_end_hold + SW'(w_m);
        w_phase    = eso_pkg::PH_DONE;
        w_elap     = '0;
        if (w_t_ext < w_end_wait) begin
            w_phase = eso_pkg::PH_WAIT;
        end else if (w_t_ext < w_end_out) begin
            w_phase = eso_pkg::PH_OUT;
            w_elap  = w_t_ext - w_end_wait;
        end else if (!r_mode && w_t_ext < w_end_hold) begin
            w_phase = eso_pkg::PH_HOLD;
        end else if (!r_mode && w_t_ext < w_end_back) begin
            w_phase = eso_pkg::PH_BACK;
            w_elap  = w_t_ext - w_end_hold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side0.vld <= 1'b0;
        end else begin
            r_side0.vld <= w_acc;
        end
        r_side0.phase <= w_phase;
        r_elap        <= w_elap[TW-1:0];
    end

    assign w_side[0] = r_side0;
    assign w_rem[0]  = r_elap;
    assign w_quo[0]  = '0;

    // row of division cells: fraction = (elapsed << FB) / move
    for (genvar g = 0; g < FB; g++) begin : g_div
        eso_div_cell #(
            .TW (TW),
            .FB (FB)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_div   (w_m),
            .i_side  (w_side[g]),
            .i_rem   (w_rem[g]),
            .i_quo   (w_quo[g]),
            .o_side  (w_side[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_quo   (w_quo[g+1])
        );
    end

    eso_ease #(
        .FB (FB)
    ) u_ease (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_mode   (r_mode),
        .i_dist   (r_dist),
        .i_side   (w_side[FB]),
        .i_frac   (w_quo[FB]),
        .o_side   (w_out_side),
        .o_offset (o_offset)
    );

    assign o_valid = w_out_side.vld;
    assign o_phase = w_out_side.phase;

endmodule

>>> sim/eased_scroll_offset_core_tb.sv
`timescale 1ns / 1ps

module eased_scroll_offset_core_tb;

    localparam int TB = eso_pkg::ESO_TIME_BITS;
    localparam int FB = eso_pkg::ESO_FRAC_BITS;
    localparam int LATENCY = FB + 6;
    localparam longint ONE = 64'd1 << FB;

    typedef struct packed {
        logic [eso_pkg::DIST_W-1:0] offset;
        eso_pkg::t_phase            phase;
    } t_scroll_res;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [eso_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [eso_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                           i_start = 1'b0;
    logic                           o_busy;
    logic [TB-1:0]                  i_now_ticks = '0;
    logic                           o_valid;
    logic [eso_pkg::DIST_W-1:0]     o_offset;
    logic [eso_pkg::PHASE_W-1:0]    o_phase;

    eased_scroll_offset_core DUT (.*);

    always #6 i_clk = ~i_clk;

    // shadow copy of the configuration
    longint unsigned sh_delay = 0, sh_move = 0, sh_dist = 0, sh_mode = 0;

    logic [TB-1:0] pending_ticks[$];
    t_scroll_res   expected_offsets[$];
    int            err_count = 0;
    int            idle_pct = 0;
    bit            cfg_req = 1'b0;
    bit            cfg_done = 1'b0;
    eso_pkg::t_cfg_idx              cfg_req_idx;
    logic [eso_pkg::CFG_DATA_W-1:0] cfg_req_data;

    function automatic longint unsigned eased(longint unsigned f);
        longint unsigned x2, x3, pos, neg, p, s;
        x2 = (f * f) >> FB;
        x3 = (x2 * f) >> FB;
        pos = 6 * x2 + 10 * ONE;
        neg = 15 * f;
        p = (pos > neg) ? pos - neg : 0;
        s = (x3 * p) >> FB;
        return (s > ONE) ? ONE : s;
    endfunction

    function automatic t_scroll_res predict_offset(logic [TB-1:0] now);
        longint unsigned t, e_wait, e_out, e_hold, e_back, f;
        t_scroll_res r;
        t = now;
        e_wait = sh_delay;
        e_out = e_wait + sh_move;
        e_hold = e_out + sh_delay;
        e_back = e_hold + sh_move;
        r.offset = '0;
        r.phase = eso_pkg::PH_DONE;
        if (t < e_wait) begin
            r.phase = eso_pkg::PH_WAIT;
        end else if (t < e_out) begin
            f = ((t - e_wait) << FB) / sh_move;
            r.phase = eso_pkg::PH_OUT;
            r.offset = sh_mode ? (sh_dist * f) >> FB : (sh_dist * eased(f)) >> FB;
        end else if (sh_mode == 0 && t < e_hold) begin
            r.phase = eso_pkg::PH_HOLD;
            r.offset = sh_dist;
        end else if (sh_mode == 0 && t < e_back) begin
            f = ((t - e_hold) << FB) / sh_move;
            r.phase = eso_pkg::PH_BACK;
            r.offset = sh_dist - ((sh_dist * eased(f)) >> FB);
        end
        return r;
    endfunction

    // driver: config beats and query beats
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                i_cfg_valid <= 1'b0;
                cfg_done <= 1'b1;
                case (eso_pkg::t_cfg_idx'(i_cfg_index))
                    eso_pkg::CFG_DELAY: sh_delay = i_cfg_data;
                    eso_pkg::CFG_MOVE:  sh_move = i_cfg_data;
                    eso_pkg::CFG_DIST:  sh_dist = i_cfg_data[eso_pkg::DIST_W-1:0];
                    eso_pkg::CFG_MODE:  sh_mode = i_cfg_data[0];
                    default: ;
                endcase
            end else if (cfg_req && !cfg_done && !i_cfg_valid) begin
                i_cfg_valid <= 1'b1;
                i_cfg_index <= cfg_req_idx;
                i_cfg_data <= cfg_req_data;
            end
            if (i_start && !o_busy) begin
                expected_offsets.push_back(predict_offset(i_now_ticks));
            end
            if (pending_ticks.size() > 0 && $urandom_range(99) >= idle_pct) begin
                i_start <= 1'b1;
                i_now_ticks <= pending_ticks.pop_front();
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // monitor: results are taken on the strobe
    always @(posedge i_clk) begin
        t_scroll_res exp_r;
        if (i_rst_n && o_valid) begin
            if (expected_offsets.size() == 0) begin
                err_count++;
                if (err_count <= 10) $display("unexpected result offset=%0h phase=%0d",
                                              o_offset, o_phase);
            end else begin
                exp_r = expected_offsets.pop_front();
                if (o_offset !== exp_r.offset || o_phase !== exp_r.phase) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("mismatch: exp offset=%0h phase=%0d got offset=%0h phase=%0d",
                                 exp_r.offset, exp_r.phase, o_offset, o_phase);
                end
            end
        end
    end

    task automatic write_reg(eso_pkg::t_cfg_idx idx, logic [eso_pkg::CFG_DATA_W-1:0] data);
        cfg_req_idx = idx;
        cfg_req_data = data;
        cfg_done = 1'b0;
        cfg_req = 1'b1;
        @(posedge i_clk);
        while (!cfg_done) @(posedge i_clk);
        cfg_req = 1'b0;
    endtask

    task automatic drain();
        while (pending_ticks.size() > 0 || i_start || expected_offsets.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic set_cfg(logic [23:0] d, logic [23:0] m, logic [15:0] s, bit md);
        drain();
        write_reg(eso_pkg::CFG_DELAY, d);
        write_reg(eso_pkg::CFG_MOVE, m);
        write_reg(eso_pkg::CFG_DIST, {8'h00, s});
        write_reg(eso_pkg::CFG_MODE, {23'd0, md});
    endtask

    // random time: full range, near the end of the moving-out phase, or within the phase span
    function automatic logic [TB-1:0] pick_ticks();
        longint unsigned span, v;
        span = 2 * (sh_delay + sh_move) + 4;
        case ($urandom_range(3))
            0: v = $urandom_range(23'h7FFFFF) * 2 + $urandom_range(1);
            1: v = sh_delay + sh_move + $urandom_range(3) - 2;
            default: v = $urandom() % span;
        endcase
        return v[TB-1:0];
    endfunction

    initial begin
        int n;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: reset config, extremes, zero move, zero delay
        pending_ticks.push_back('0);
        pending_ticks.push_back('1);
        set_cfg(24'd10, 24'd0, 16'hFFFF, 1'b0);
        for (int k = 8; k < 13; k++) pending_ticks.push_back(TB'(k));
        set_cfg(24'd0, 24'd8, 16'hFFFF, 1'b0);
        for (int k = 0; k < 18; k++) pending_ticks.push_back(TB'(k));
        set_cfg(24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 1'b1);
        pending_ticks.push_back(24'hFFFFFE);
        pending_ticks.push_back(24'hFFFFFF);
        set_cfg(24'h7FFFFF, 24'h7FFFFF, 16'h8001, 1'b0);
        pending_ticks.push_back(24'hFFFFFF);
        // random phases with three idling profiles
        for (int ph = 0; ph < 6; ph++) begin
            idle_pct = (ph < 2) ? 28 : (ph < 4) ? 59 : 0;
            case (ph)
                0: set_cfg(24'($urandom_range(50)), 24'($urandom_range(1, 300)),
                           16'($urandom()), 1'b0);
                1: set_cfg(24'($urandom_range(2000)), 24'($urandom_range(50000)),
                           16'($urandom()), 1'b1);
                2: set_cfg(24'($urandom()), 24'($urandom()), 16'hFFFF, 1'b0);
                3: set_cfg(24'd0, 24'($urandom_range(1, 4)), 16'($urandom()),
                           1'($urandom_range(1)));
                4: set_cfg(24'($urandom_range(9)), 24'($urandom_range(1, 99)),
                           16'($urandom()), 1'b0);
                default: set_cfg(24'hFFFFFF, 24'd1, 16'd0, 1'b0);
            endcase
            n = (ph == 5) ? 100 : 170;
            for (int k = 0; k < n; k++) pending_ticks.push_back(pick_ticks());
        end
        drain();
        if (err_count == 0 && expected_offsets.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
